@@ hw/rtl/delta_timer_queue_defines.svh @@
// Assertion macros used by the delta timer queue checker.
`ifndef DELTA_TIMER_QUEUE_DEFINES_SVH
`define DELTA_TIMER_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define DTQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define DTQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/dtq_pkg.sv @@
// Package with types and constants of the delta timer queue.
package dtq_pkg;

  localparam int DEFAULT_CAPACITY = 16;
  localparam int TAG_W            = 8;
  localparam int TIME_W           = 32;
  localparam int OP_W             = 2;

  localparam logic [TIME_W-1:0] MAX_DURATION_RESET = '1;

  localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
  localparam logic [OP_W-1:0] OP_CANCEL = 2'd1;
  localparam logic [OP_W-1:0] OP_EXPIRE = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DECIDE,
    ST_PUSH_A,
    ST_PUSH_B,
    ST_PUSH_C,
    ST_DROP_A,
    ST_DROP_W,
    ST_DROP_B,
    ST_DROP_C,
    ST_SCAN_W,
    ST_SCAN,
    ST_SHIFT_A,
    ST_SHIFT_W,
    ST_SHIFT_B,
    ST_FIX,
    ST_FIX_W,
    ST_FIX_B,
    ST_DONE
  } state_t;

endpackage

@@ hw/rtl/delta_timer_queue.sv @@
// Delta-list timer queue: ring of tags and delta times driving one hardware countdown.
// A cancel scans the ring slot by slot for the tag and shifts each later slot down to close the gap.
// One item at a time; busy stays high through the done strobe.
// All steps share one 32-bit add/subtract unit and one read port of the ring memory.
// Synchronous active-high reset empties the ring and sets max_duration to all ones.
module delta_timer_queue
  import dtq_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [OP_W-1:0]   opcode,
  input  logic [TAG_W-1:0]  seq_tag,
  input  logic [TIME_W-1:0] duration,
  input  logic [TIME_W-1:0] hw_left,
  output logic              done,
  output logic              status,
  output logic [TIME_W-1:0] reload_time,
  output logic              stop_hw,
  output logic [TAG_W-1:0]  fired_tag,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [TIME_W-1:0] cfg_data
);

  localparam int SLOTS = CAPACITY + 1;
  localparam int PTR_W = $clog2(SLOTS);

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(SLOTS - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] prev_ptr(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(CAPACITY) : p - PTR_W'(1);
  endfunction

  // Ring memory
  logic [TAG_W-1:0]  tag_mem   [SLOTS];
  logic [TIME_W-1:0] delta_mem [SLOTS];
  logic [TAG_W-1:0]  rd_tag;
  logic [TIME_W-1:0] rd_delta;
  logic              tag_we;
  logic              delta_we;
  logic [PTR_W-1:0]  waddr;
  logic [TAG_W-1:0]  wtag;
  logic [TIME_W-1:0] wdelta;

  state_t            state, state_next;
  logic [PTR_W-1:0]  head, head_next;
  logic [PTR_W-1:0]  tail, tail_next;
  logic [PTR_W-1:0]  idx, idx_next;
  logic [PTR_W-1:0]  wptr, wptr_next;
  logic [PTR_W-1:0]  tpos, tpos_next;
  logic [TIME_W-1:0] delta_sum, delta_sum_next;
  logic [TIME_W-1:0] acc, acc_next;
  logic [TIME_W-1:0] max_duration;
  logic [OP_W-1:0]   cur_op, cur_op_next;
  logic [TAG_W-1:0]  cur_tag, cur_tag_next;
  logic [TIME_W-1:0] cur_dur, cur_dur_next;
  logic [TIME_W-1:0] cur_left, cur_left_next;
  logic              status_next;
  logic [TIME_W-1:0] reload_time_next;
  logic              stop_hw_next;
  logic [TAG_W-1:0]  fired_tag_next;

  // Shared add/subtract unit
  logic [TIME_W-1:0] alu_a, alu_b, alu_out;
  logic              alu_sub;

  assign alu_out = alu_a + (alu_sub ? ~alu_b : alu_b) + TIME_W'(alu_sub);

  assign busy      = (state != ST_IDLE);
  assign done      = (state == ST_DONE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[waddr] <= wtag;
    end
    if (delta_we) begin
      delta_mem[waddr] <= wdelta;
    end
    rd_tag   <= tag_mem[idx];
    rd_delta <= delta_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      head         <= '0;
      tail         <= '0;
      delta_sum    <= '0;
      max_duration <= MAX_DURATION_RESET;
    end else begin
      state     <= state_next;
      head      <= head_next;
      tail      <= tail_next;
      delta_sum <= delta_sum_next;
      if (cfg_valid && cfg_ready) begin
        max_duration <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx         <= idx_next;
    wptr        <= wptr_next;
    tpos        <= tpos_next;
    acc         <= acc_next;
    cur_op      <= cur_op_next;
    cur_tag     <= cur_tag_next;
    cur_dur     <= cur_dur_next;
    cur_left    <= cur_left_next;
    status      <= status_next;
    reload_time <= reload_time_next;
    stop_hw     <= stop_hw_next;
    fired_tag   <= fired_tag_next;
  end

  always_comb begin
    state_next       = state;
    head_next        = head;
    tail_next        = tail;
    idx_next         = idx;
    wptr_next        = wptr;
    tpos_next        = tpos;
    delta_sum_next   = delta_sum;
    acc_next         = acc;
    cur_op_next      = cur_op;
    cur_tag_next     = cur_tag;
    cur_dur_next     = cur_dur;
    cur_left_next    = cur_left;
    status_next      = status;
    reload_time_next = reload_time;
    stop_hw_next     = stop_hw;
    fired_tag_next   = fired_tag;
    tag_we           = 1'b0;
    delta_we         = 1'b0;
    waddr            = head;
    wtag             = cur_tag;
    wdelta           = cur_dur;
    alu_a            = delta_sum;
    alu_b            = acc;
    alu_sub          = 1'b1;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cur_op_next      = opcode;
          cur_tag_next     = seq_tag;
          cur_dur_next     = duration;
          cur_left_next    = hw_left;
          idx_next         = tail;
          status_next      = 1'b1;
          reload_time_next = '0;
          stop_hw_next     = 1'b0;
          fired_tag_next   = '0;
          state_next       = ST_LOAD;
        end
      end

      // Wait for the tail slot to be read.
      ST_LOAD: state_next = ST_DECIDE;

      ST_DECIDE: begin
        state_next = ST_DONE;
        unique case (cur_op)
          OP_PUSH: begin
            if (next_ptr(head) != tail && cur_dur <= max_duration) begin
              if (head == tail) begin
                tag_we           = 1'b1;
                delta_we         = 1'b1;
                reload_time_next = cur_dur;
                head_next        = next_ptr(head);
                status_next      = 1'b0;
              end else begin
                state_next = ST_PUSH_A;
              end
            end
          end
          OP_CANCEL: begin
            if (head != tail) begin
              if (rd_tag == cur_tag) begin
                stop_hw_next = 1'b1;
                state_next   = ST_DROP_A;
              end else begin
                idx_next   = next_ptr(tail);
                state_next = ST_SCAN_W;
              end
            end
          end
          OP_EXPIRE: begin
            fired_tag_next = rd_tag;
            if (head != tail) begin
              state_next = ST_DROP_A;
            end
          end
          default: state_next = ST_DONE;
        endcase
      end

      ST_PUSH_A: begin
        alu_a      = cur_dur;
        alu_b      = cur_left;
        acc_next   = alu_out;
        state_next = ST_PUSH_B;
      end

      ST_PUSH_B: begin
        alu_a      = acc;
        alu_b      = delta_sum;
        acc_next   = alu_out;
        tag_we     = 1'b1;
        delta_we   = 1'b1;
        wdelta     = alu_out;
        state_next = ST_PUSH_C;
      end

      ST_PUSH_C: begin
        alu_a          = delta_sum;
        alu_b          = acc;
        alu_sub        = 1'b0;
        delta_sum_next = alu_out;
        head_next      = next_ptr(head);
        status_next    = 1'b0;
        state_next     = ST_DONE;
      end

      // Drop the tail entry; the successor takes over the hardware countdown.
      ST_DROP_A: begin
        status_next = 1'b0;
        if (next_ptr(tail) == head) begin
          tail_next  = next_ptr(tail);
          state_next = ST_DONE;
        end else begin
          idx_next   = next_ptr(tail);
          state_next = ST_DROP_W;
        end
      end

      ST_DROP_W: state_next = ST_DROP_B;

      ST_DROP_B: begin
        alu_a          = delta_sum;
        alu_b          = rd_delta;
        delta_sum_next = alu_out;
        state_next     = ST_DROP_C;
      end

      ST_DROP_C: begin
        alu_a            = rd_delta;
        alu_b            = cur_left;
        alu_sub          = 1'b0;
        delta_we         = 1'b1;
        waddr            = idx;
        wdelta           = alu_out;
        reload_time_next = alu_out;
        tail_next        = idx;
        state_next       = ST_DONE;
      end

      ST_SCAN_W: state_next = ST_SCAN;

      ST_SCAN: begin
        if (idx == head) begin
          state_next = ST_DONE;
        end else if (rd_tag == cur_tag) begin
          tpos_next  = idx;
          acc_next   = rd_delta;
          state_next = ST_SHIFT_A;
        end else begin
          idx_next   = next_ptr(idx);
          state_next = ST_SCAN_W;
        end
      end

      // Close the gap: move each later entry down one slot.
      ST_SHIFT_A: begin
        if (next_ptr(idx) == head) begin
          state_next = ST_FIX;
        end else begin
          wptr_next  = idx;
          idx_next   = next_ptr(idx);
          state_next = ST_SHIFT_W;
        end
      end

      ST_SHIFT_W: state_next = ST_SHIFT_B;

      ST_SHIFT_B: begin
        tag_we     = 1'b1;
        delta_we   = 1'b1;
        waddr      = wptr;
        wtag       = rd_tag;
        wdelta     = rd_delta;
        state_next = ST_SHIFT_A;
      end

      // Fold the removed delta into its successor, or out of the sum if it was newest.
      ST_FIX: begin
        head_next   = prev_ptr(head);
        status_next = 1'b0;
        if (tpos == prev_ptr(head)) begin
          alu_a          = delta_sum;
          alu_b          = acc;
          delta_sum_next = alu_out;
          state_next     = ST_DONE;
        end else begin
          idx_next   = tpos;
          state_next = ST_FIX_W;
        end
      end

      ST_FIX_W: state_next = ST_FIX_B;

      ST_FIX_B: begin
        alu_a      = rd_delta;
        alu_b      = acc;
        alu_sub    = 1'b0;
        delta_we   = 1'b1;
        waddr      = idx;
        wdelta     = alu_out;
        state_next = ST_DONE;
      end

      ST_DONE: state_next = ST_IDLE;

      default: state_next = ST_IDLE;
    endcase
  end

endmodule

@@ hw/rtl/delta_timer_queue_chk.sv @@
// Port-level checker for the delta timer queue, bound to the top level.
`include "delta_timer_queue_defines.svh"

module delta_timer_queue_chk
  import dtq_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input logic              status,
  input logic [TIME_W-1:0] reload_time,
  input logic              stop_hw
);

  `DTQ_ASSERT_NOW(a_done_busy, clk, rst, done, busy, "done strobe while not busy")
  `DTQ_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy, "accepted item did not raise busy")
  `DTQ_ASSERT_NEXT(a_done_idle, clk, rst, done, !busy && !done, "block still busy after done")
  `DTQ_ASSERT_NOW(a_stop_ok, clk, rst, done && stop_hw, !status, "stop_hw on rejected item")
  `DTQ_ASSERT_NOW(a_rej_reload, clk, rst, done && status, reload_time == '0, "reload on rejected item")

endmodule

bind delta_timer_queue delta_timer_queue_chk u_chk (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .status      (status),
  .reload_time (reload_time),
  .stop_hw     (stop_hw)
);

@@ tb/delta_timer_queue_tb.sv @@
// Self-checking testbench for delta_timer_queue: predicts each push, cancel and expire result.
module delta_timer_queue_tb;
  import dtq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY = DEFAULT_CAPACITY;
  localparam int SLOTS    = CAPACITY + 1;

  // Opcode the block ignores.
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

  typedef struct packed {
    logic              status;
    logic [TIME_W-1:0] reload;
    logic              stop;
    logic [TAG_W-1:0]  fired;
  } timer_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [OP_W-1:0]   opcode = '0;
  logic [TAG_W-1:0]  seq_tag = '0;
  logic [TIME_W-1:0] duration = '0;
  logic [TIME_W-1:0] hw_left = '0;
  logic              done;
  logic              status;
  logic [TIME_W-1:0] reload_time;
  logic              stop_hw;
  logic [TAG_W-1:0]  fired_tag;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [TIME_W-1:0] cfg_data = '0;

  // Shadow copy of the timer ring.
  logic [TAG_W-1:0]  ring_tag   [SLOTS];
  logic [TIME_W-1:0] ring_delta [SLOTS];
  bit                slot_written [SLOTS];
  int                head_idx = 0;
  int                tail_idx = 0;
  logic [TIME_W-1:0] pend_sum = '0;
  logic [TIME_W-1:0] max_dur_cfg = MAX_DURATION_RESET;

  timer_result_t     pending_results [$];
  int                error_count = 0;

  delta_timer_queue #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .opcode     (opcode),
    .seq_tag    (seq_tag),
    .duration   (duration),
    .hw_left    (hw_left),
    .done       (done),
    .status     (status),
    .reload_time(reload_time),
    .stop_hw    (stop_hw),
    .fired_tag  (fired_tag),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int next_slot(input int p);
    return (p + 1) % SLOTS;
  endfunction

  function automatic int prev_slot(input int p);
    return (p == 0) ? CAPACITY : p - 1;
  endfunction

  function automatic int ring_count();
    return (head_idx - tail_idx + SLOTS) % SLOTS;
  endfunction

  // Retire the running timer and hand back the next reload value.
  function automatic logic [TIME_W-1:0] pop_running(input logic [TIME_W-1:0] left);
    if (next_slot(tail_idx) == head_idx) begin
      tail_idx = next_slot(tail_idx);
      return '0;
    end
    tail_idx = next_slot(tail_idx);
    pend_sum = pend_sum - ring_delta[tail_idx];
    ring_delta[tail_idx] = ring_delta[tail_idx] + left;
    return ring_delta[tail_idx];
  endfunction

  function automatic timer_result_t predict_timer_op(input logic [OP_W-1:0] op,
                                                     input logic [TAG_W-1:0] tag,
                                                     input logic [TIME_W-1:0] dur,
                                                     input logic [TIME_W-1:0] left);
    timer_result_t r;
    bit empty;
    int t;
    int i;
    logic [TIME_W-1:0] removed;
    r = '{status: 1'b1, reload: '0, stop: 1'b0, fired: '0};
    empty = (head_idx == tail_idx);
    case (op)
      OP_PUSH: begin
        if (next_slot(head_idx) != tail_idx && dur <= max_dur_cfg) begin
          ring_tag[head_idx] = tag;
          slot_written[head_idx] = 1'b1;
          if (empty) begin
            ring_delta[head_idx] = dur;
            r.reload = dur;
          end else begin
            ring_delta[head_idx] = dur - left - pend_sum;
            pend_sum = pend_sum + ring_delta[head_idx];
          end
          head_idx = next_slot(head_idx);
          r.status = 1'b0;
        end
      end
      OP_CANCEL: begin
        if (!empty) begin
          if (ring_tag[tail_idx] == tag) begin
            r.reload = pop_running(left);
            r.stop = 1'b1;
            r.status = 1'b0;
          end else begin
            t = tail_idx;
            while (t != head_idx && ring_tag[t] != tag) t = next_slot(t);
            if (t != head_idx) begin
              removed = ring_delta[t];
              i = t;
              // Close the gap toward the tail.
              while (next_slot(i) != head_idx) begin
                ring_tag[i] = ring_tag[next_slot(i)];
                ring_delta[i] = ring_delta[next_slot(i)];
                i = next_slot(i);
              end
              head_idx = prev_slot(head_idx);
              if (t == head_idx) pend_sum = pend_sum - removed;
              else ring_delta[t] = ring_delta[t] + removed;
              r.status = 1'b0;
            end
          end
        end
      end
      OP_EXPIRE: begin
        r.fired = ring_tag[tail_idx];
        if (!empty) begin
          r.reload = pop_running(left);
          r.status = 1'b0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Inputs move at the falling edge; a transfer happens at a rising edge with busy low.
  task automatic send_timer_op(input logic [OP_W-1:0] op, input logic [TAG_W-1:0] tag,
                               input logic [TIME_W-1:0] dur, input logic [TIME_W-1:0] left);
    @(negedge clk);
    start    = 1'b1;
    opcode   = op;
    seq_tag  = tag;
    duration = dur;
    hw_left  = left;
    do @(posedge clk); while (busy);
    pending_results.push_back(predict_timer_op(op, tag, dur, left));
  endtask

  task automatic hold_off(input int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Drop start and hold until every result is in and the block is idle.
  task automatic wait_results_drained();
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    do @(posedge clk); while (busy);
  endtask

  task automatic write_max_duration(input logic [TIME_W-1:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    max_dur_cfg = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_random_op(input int push_pct, output bit counted);
    int roll;
    int cnt;
    logic [OP_W-1:0]   op;
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] dur;
    logic [TIME_W-1:0] left;
    cnt  = ring_count();
    roll = $urandom_range(0, 99);
    if (roll < 4) op = OP_NONE;
    else if (roll < 4 + push_pct * 96 / 100) op = OP_PUSH;
    else if ($urandom_range(0, 99) < 55) op = OP_CANCEL;
    else op = OP_EXPIRE;
    // An empty-ring expire reports the stale tail tag; only allow it once that slot was written.
    if (op == OP_EXPIRE && cnt == 0 && !slot_written[tail_idx]) op = OP_CANCEL;

    roll = $urandom_range(0, 99);
    if (op == OP_CANCEL && cnt > 0 && roll < 30) tag = ring_tag[tail_idx];
    else if (op == OP_CANCEL && cnt > 0 && roll < 80)
      tag = ring_tag[(tail_idx + $urandom_range(0, cnt - 1)) % SLOTS];
    else if (roll < 90) tag = TAG_W'($urandom_range(0, 15));
    else tag = TAG_W'($urandom);

    roll = $urandom_range(0, 99);
    if (roll < 10) dur = max_dur_cfg;
    else if (roll < 20) dur = max_dur_cfg + 1;
    else if (roll < 70) dur = $urandom_range(0, 100000);
    else dur = $urandom;

    left = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 5000) : $urandom;
    send_timer_op(op, tag, dur, left);
    counted = (op != OP_NONE);
  endtask

  task automatic test_directed_ops();
    send_timer_op(OP_PUSH,   8'h00, 32'd0,         32'd0);
    send_timer_op(OP_PUSH,   8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_timer_op(OP_PUSH,   8'h11, 32'd500,       32'd20);
    send_timer_op(OP_PUSH,   8'h22, 32'd900,       32'd30);
    // Middle entry: its delta folds into the successor.
    send_timer_op(OP_CANCEL, 8'h11, 32'd0,         32'd40);
    // Newest entry: its delta leaves the running sum.
    send_timer_op(OP_CANCEL, 8'h22, 32'd0,         32'd50);
    send_timer_op(OP_CANCEL, 8'h5A, 32'd0,         32'd60);
    // Running timer with a successor: stop and reload.
    send_timer_op(OP_CANCEL, 8'h00, 32'hFFFF_FFFF, 32'd70);
    send_timer_op(OP_EXPIRE, 8'h00, 32'd0,         32'd80);
    send_timer_op(OP_EXPIRE, 8'hFF, 32'd0,         32'd90);
    send_timer_op(OP_CANCEL, 8'h22, 32'd0,         32'd0);
    send_timer_op(OP_NONE,   8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_timer_op(OP_PUSH,   8'hA5, 32'd1000,      32'd0);
    send_timer_op(OP_PUSH,   8'h5A, 32'd300,       32'd900);
    send_timer_op(OP_CANCEL, 8'hA5, 32'd0,         32'd123);
    send_timer_op(OP_EXPIRE, 8'h00, 32'd0,         32'd12345);
    wait_results_drained();
  endtask

  task automatic test_duration_limit();
    write_max_duration(32'd1000);
    send_timer_op(OP_PUSH,   8'h01, 32'd1000, 32'd0);
    send_timer_op(OP_PUSH,   8'h02, 32'd1001, 32'd10);
    send_timer_op(OP_PUSH,   8'h03, 32'd0,    32'd10);
    wait_results_drained();
    write_max_duration(32'd0);
    send_timer_op(OP_PUSH,   8'h04, 32'd0,    32'd5);
    send_timer_op(OP_PUSH,   8'h05, 32'd1,    32'd5);
    send_timer_op(OP_EXPIRE, 8'h00, 32'd0,    32'd7);
    send_timer_op(OP_EXPIRE, 8'h00, 32'd0,    32'd8);
    send_timer_op(OP_EXPIRE, 8'h00, 32'd0,    32'd9);
    wait_results_drained();
  endtask

  task automatic test_random_traffic();
    logic [TIME_W-1:0] limits [7];
    int push_mix [7];
    int sent;
    bit counted;
    limits[0] = '1;            push_mix[0] = 60;
    limits[1] = '0;            push_mix[1] = 85;
    limits[2] = 32'd1;         push_mix[2] = 50;
    limits[3] = 32'd1000;      push_mix[3] = 70;
    limits[4] = 32'h8000_0000; push_mix[4] = 30;
    limits[5] = $urandom;      push_mix[5] = 55;
    limits[6] = '1;            push_mix[6] = 85;
    for (int ph = 0; ph < 7; ph++) begin
      write_max_duration(limits[ph]);
      sent = 0;
      while (sent < 180) begin
        send_random_op(push_mix[ph], counted);
        if (counted) sent++;
        // Phase 2 runs back to back.
        if (ph != 2) hold_off(pick_gap());
        if ($urandom_range(0, 99) == 0) wait_results_drained();
      end
      wait_results_drained();
    end
  endtask

  always @(posedge clk) begin : check_results
    timer_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status=%0b reload=%h stop=%0b fired=%h",
                 $time, status, reload_time, stop_hw, fired_tag);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) begin
          $display("%0t: status expected %0b got %0b", $time, want.status, status);
          error_count++;
        end
        if (reload_time !== want.reload) begin
          $display("%0t: reload_time expected %h got %h", $time, want.reload, reload_time);
          error_count++;
        end
        if (stop_hw !== want.stop) begin
          $display("%0t: stop_hw expected %0b got %0b", $time, want.stop, stop_hw);
          error_count++;
        end
        if (fired_tag !== want.fired) begin
          $display("%0t: fired_tag expected %h got %h", $time, want.fired, fired_tag);
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed_ops();
    test_duration_limit();
    test_random_traffic();
    wait_results_drained();
    repeat (100) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(10ms);
    $display("%0t: timeout", $time);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/dtq_pkg.sv
hw/rtl/delta_timer_queue.sv
hw/rtl/delta_timer_queue_chk.sv
tb/delta_timer_queue_tb.sv
